@@ design/tte_pkg.sv @@
// ----------------------------------------------------------------------------
// Tap tempo estimator package
// Sizes, register indexes and the sequencer program shared by the design.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int RING_DEPTH = 8;
  localparam int SlotW      = $clog2(RING_DEPTH);
  localparam int CntW       = $clog2(RING_DEPTH + 1);
  localparam int IvW        = 24;
  localparam int TapW       = 32;
  localparam int TempoW     = 20;
  localparam int SumW       = IvW + SlotW;
  localparam int NumW       = 34 + CntW;
  localparam int DcntW      = $clog2(NumW);
  localparam int UpcW       = 3;

  // 60e6 us/min times 256, added once per held interval
  localparam logic [NumW-1:0]   NumPerIv = NumW'(64'd15360000000);
  localparam logic [TempoW-1:0] TempoMax = '1;

  typedef enum logic [0:0] {
    CFG_MIN_INTERVAL = 1'b0,
    CFG_MAX_INTERVAL = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_TAKE,
    OP_CLASSIFY,
    OP_CLEAR,
    OP_READ,
    OP_ACC,
    OP_DIV,
    OP_LOAD,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_INPUT,
    COND_NO_TEMPO,
    COND_MORE,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UpcW-1:0]  target;
  } uword_t;

  localparam logic [UpcW-1:0] UpcWait     = 3'd0;
  localparam logic [UpcW-1:0] UpcClassify = 3'd1;
  localparam logic [UpcW-1:0] UpcClear    = 3'd2;
  localparam logic [UpcW-1:0] UpcRead     = 3'd3;
  localparam logic [UpcW-1:0] UpcAcc      = 3'd4;
  localparam logic [UpcW-1:0] UpcDiv      = 3'd5;
  localparam logic [UpcW-1:0] UpcLoad     = 3'd6;
  localparam logic [UpcW-1:0] UpcEmit     = 3'd7;

  // Program: a taken jump goes to target, otherwise fall through to pc + 1.
  function automatic uword_t ucode_rom(logic [UpcW-1:0] pc);
    uword_t w;
    case (pc)
      UpcWait:     w = '{op: OP_TAKE,     cond: COND_NO_INPUT, target: UpcWait};
      UpcClassify: w = '{op: OP_CLASSIFY, cond: COND_NEVER,    target: UpcWait};
      UpcClear:    w = '{op: OP_CLEAR,    cond: COND_NO_TEMPO, target: UpcEmit};
      UpcRead:     w = '{op: OP_READ,     cond: COND_NEVER,    target: UpcWait};
      UpcAcc:      w = '{op: OP_ACC,      cond: COND_MORE,     target: UpcRead};
      UpcDiv:      w = '{op: OP_DIV,      cond: COND_DIV_MORE, target: UpcDiv};
      UpcLoad:     w = '{op: OP_LOAD,     cond: COND_NEVER,    target: UpcWait};
      UpcEmit:     w = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: UpcEmit};
      default:     w = '{op: OP_TAKE,     cond: COND_NEVER,    target: UpcWait};
    endcase
    return w;
  endfunction

endpackage

@@ design/tap_tempo_estimator_core.sv @@
// ----------------------------------------------------------------------------
// Tap tempo estimator core
// Averages recent tap intervals and reports tempo in BPM times 256.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one tap timestamp per
//   request. Output channel (out_valid_o/out_ready_i) returns one result per
//   tap: held tempo, a tempo-updated flag and an interval-accepted flag.
//   Config channel writes min/max interval limits (index 0 and 1); write it
//   only while no tap is in flight. It is always ready.
//   A tap that does not update the tempo passes the take, classify, clear
//   and emit steps. A tap that updates it also runs the read, accumulate,
//   divide and load steps, N being the number of held intervals (at most
//   8): the sum walks the interval RAM with a read step and an accumulate
//   step per entry, and the divider makes one quotient bit a cycle. A
//   microcoded sequencer steps through the work, so one tap is handled at a
//   time; the next tap is taken as soon as the result sits in the output
//   register. If the receiver stalls with a result still held, the
//   sequencer waits at the emit step.
//   Reset clears the limits to 150000/2500000 us, the held tempo, the
//   interval count and the first-tap flag. No clearing pass is needed.
// ----------------------------------------------------------------------------
module tap_tempo_estimator_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  tte_pkg::cfg_idx_e      cfg_index_i,
  input  logic [23:0]            cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [31:0]            tap_time_us_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [19:0]            tempo_bpm_q8_o,
  output logic                   tempo_updated_o,
  output logic                   interval_accepted_o
);
  import tte_pkg::*;

  // control state
  logic [UpcW-1:0]   upc_q, upc_d;
  logic [IvW-1:0]    min_q, min_d, max_q, max_d;
  logic [TapW-1:0]   last_q, last_d;
  logic              seen_q, seen_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [TempoW-1:0] held_q, held_d;
  logic              upd_q, upd_d, acc_q, acc_d;
  logic              out_valid_q, out_valid_d;

  // datapath
  logic [TapW-1:0]   tap_q, tap_d;
  logic [SumW-1:0]   sum_q, sum_d, rem_q, rem_d;
  logic [NumW-1:0]   num_q, num_d;
  logic [CntW-1:0]   k_q, k_d;
  logic [DcntW-1:0]  dcnt_q, dcnt_d;
  logic [TempoW-1:0] quo_q, quo_d;
  logic              ovf_q, ovf_d;
  logic [TempoW-1:0] out_tempo_q, out_tempo_d;
  logic              out_upd_q, out_upd_d, out_acc_q, out_acc_d;

  // RAM port
  logic              ram_we;
  logic [SlotW-1:0]  ram_raddr;
  logic [IvW-1:0]    ram_rdata;

  uword_t            uw;
  logic              cond_hit;
  logic [TapW-1:0]   delta;
  logic              in_range;
  logic [SumW:0]     rem_sh;
  logic              ge;

  assign uw          = ucode_rom(upc_q);
  assign delta       = tap_q - last_q;
  assign in_range    = (delta > {8'd0, min_q}) && (delta < {8'd0, max_q});
  assign rem_sh      = {rem_q, num_q[NumW-1]};
  assign ge          = rem_sh >= {1'b0, sum_q};
  assign ram_raddr   = k_q[SlotW-1:0];
  assign ram_we      = (uw.op == OP_CLASSIFY) && seen_q && in_range;

  assign cfg_ready_o         = 1'b1;
  assign in_ready_o          = (uw.op == OP_TAKE);
  assign out_valid_o         = out_valid_q;
  assign tempo_bpm_q8_o      = out_tempo_q;
  assign tempo_updated_o     = out_upd_q;
  assign interval_accepted_o = out_acc_q;

  always_comb begin
    case (uw.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_NO_INPUT: cond_hit = !in_valid_i;
      COND_NO_TEMPO: cond_hit = !acc_q || (fill_q < CntW'(2));
      COND_MORE:     cond_hit = (k_q + CntW'(1)) != fill_q;
      COND_DIV_MORE: cond_hit = dcnt_q != DcntW'(NumW - 1);
      COND_OUT_BUSY: cond_hit = out_valid_q && !out_ready_i;
      default:       cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    upc_d       = cond_hit ? uw.target : upc_q + UpcW'(1);
    min_d       = min_q;
    max_d       = max_q;
    last_d      = last_q;
    seen_d      = seen_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    held_d      = held_q;
    upd_d       = upd_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q;
    tap_d       = tap_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    num_d       = num_q;
    k_d         = k_q;
    dcnt_d      = dcnt_q;
    quo_d       = quo_q;
    ovf_d       = ovf_q;
    out_tempo_d = out_tempo_q;
    out_upd_d   = out_upd_q;
    out_acc_d   = out_acc_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MIN_INTERVAL: min_d = cfg_data_i;
        CFG_MAX_INTERVAL: max_d = cfg_data_i;
        default: ;
      endcase
    end

    // drop the output once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (uw.op)
      OP_TAKE: begin
        if (in_valid_i) begin
          tap_d = tap_time_us_i;
        end
      end
      OP_CLASSIFY: begin
        upd_d  = 1'b0;
        acc_d  = 1'b0;
        seen_d = 1'b1;
        last_d = tap_q;
        if (seen_q) begin
          if (in_range) begin
            acc_d  = 1'b1;
            slot_d = (slot_q == SlotW'(RING_DEPTH - 1)) ? '0 : slot_q + SlotW'(1);
            if (fill_q != CntW'(RING_DEPTH)) begin
              fill_d = fill_q + CntW'(1);
            end
          end else begin
            fill_d = '0;
            slot_d = '0;
          end
        end
      end
      OP_CLEAR: begin
        sum_d  = '0;
        num_d  = '0;
        k_d    = '0;
        rem_d  = '0;
        quo_d  = '0;
        ovf_d  = 1'b0;
        dcnt_d = '0;
      end
      OP_READ: ;
      OP_ACC: begin
        sum_d = sum_q + SumW'(ram_rdata);
        num_d = num_q + NumPerIv;
        k_d   = k_q + CntW'(1);
      end
      OP_DIV: begin
        rem_d  = ge ? SumW'(rem_sh - {1'b0, sum_q}) : rem_sh[SumW-1:0];
        num_d  = {num_q[NumW-2:0], 1'b0};
        quo_d  = {quo_q[TempoW-2:0], ge};
        ovf_d  = ovf_q | quo_q[TempoW-1];
        dcnt_d = dcnt_q + DcntW'(1);
      end
      OP_LOAD: begin
        held_d = ovf_q ? TempoMax : quo_q;
        upd_d  = 1'b1;
      end
      OP_EMIT: begin
        if (!cond_hit) begin
          out_valid_d = 1'b1;
          out_tempo_d = held_q;
          out_upd_d   = upd_q;
          out_acc_d   = acc_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= UpcWait;
      min_q       <= IvW'(150000);
      max_q       <= IvW'(2500000);
      last_q      <= '0;
      seen_q      <= 1'b0;
      slot_q      <= '0;
      fill_q      <= '0;
      held_q      <= '0;
      upd_q       <= 1'b0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      min_q       <= min_d;
      max_q       <= max_d;
      last_q      <= last_d;
      seen_q      <= seen_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      held_q      <= held_d;
      upd_q       <= upd_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tap_q       <= tap_d;
    sum_q       <= sum_d;
    rem_q       <= rem_d;
    num_q       <= num_d;
    k_q         <= k_d;
    dcnt_q      <= dcnt_d;
    quo_q       <= quo_d;
    ovf_q       <= ovf_d;
    out_tempo_q <= out_tempo_d;
    out_upd_q   <= out_upd_d;
    out_acc_q   <= out_acc_d;
  end

  tte_ram #(
    .Width (IvW),
    .Depth (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (delta[IvW-1:0]),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

@@ design/tte_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tte_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ tb/tempo_report_checker.sv @@
// ----------------------------------------------------------------------------
// Tempo report checker
// Watches the config, tap and report channels of the tap tempo core, keeps its
// own model of the interval ring and limits, and compares every report taken
// from the core with the oldest predicted one.
// ----------------------------------------------------------------------------
module tempo_report_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  tte_pkg::cfg_idx_e  cfg_index_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [31:0]        tap_time_us_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [19:0]        tempo_bpm_q8_i,
  input  logic               tempo_updated_i,
  input  logic               interval_accepted_i,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o
);
  import tte_pkg::*;

  // microseconds per minute times 256
  localparam logic [63:0] BpmQ8Scale = 64'd15360000000;

  typedef struct packed {
    logic [19:0] tempo;
    logic        updated;
    logic        accepted;
  } tempo_report_t;

  logic [23:0]   lim_min;
  logic [23:0]   lim_max;
  logic [31:0]   last_tap;
  logic          have_last_tap;
  logic [31:0]   ring_iv [RING_DEPTH];
  int unsigned   ring_slot;
  int unsigned   ring_fill;
  logic [19:0]   tempo_held;
  tempo_report_t reports_q [$];

  function automatic tempo_report_t predict_tap_report(input logic [31:0] now);
    tempo_report_t rep;
    logic [31:0]   gap;
    logic [63:0]   total;
    logic [63:0]   quot;
    rep.updated  = 1'b0;
    rep.accepted = 1'b0;
    if (have_last_tap) begin
      gap = now - last_tap;
      if (gap > {8'h0, lim_min} && gap < {8'h0, lim_max}) begin
        ring_iv[ring_slot] = gap;
        ring_slot = (ring_slot + 1) % RING_DEPTH;
        if (ring_fill < RING_DEPTH) ring_fill++;
        rep.accepted = 1'b1;
        if (ring_fill >= 2) begin
          total = '0;
          for (int k = 0; k < ring_fill; k++) total += ring_iv[k];
          quot = (BpmQ8Scale * ring_fill) / total;
          tempo_held = (quot > TempoMax) ? TempoMax : quot[19:0];
          rep.updated = 1'b1;
        end
      end else begin
        // out of range: restart the average
        ring_fill = 0;
        ring_slot = 0;
      end
    end
    have_last_tap = 1'b1;
    last_tap      = now;
    rep.tempo     = tempo_held;
    return rep;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tempo_report_t want;
    if (!rst_ni) begin
      lim_min       = 24'd150000;
      lim_max       = 24'd2500000;
      last_tap      = '0;
      have_last_tap = 1'b0;
      ring_slot     = 0;
      ring_fill     = 0;
      tempo_held    = '0;
      reports_q.delete();
      mismatches_o  = 0;
      pending_o     = 0;
    end else begin
      // compare before queuing a new request: a tap cannot report in its own cycle
      if (out_valid_i && out_ready_i) begin
        if (reports_q.size() == 0) begin
          $error("tempo report with none pending: tempo_bpm_q8 %0d", tempo_bpm_q8_i);
          mismatches_o++;
        end else begin
          want = reports_q.pop_front();
          if (tempo_bpm_q8_i !== want.tempo) begin
            $error("tempo_bpm_q8: expected %0d, actual %0d", want.tempo, tempo_bpm_q8_i);
            mismatches_o++;
          end
          if (tempo_updated_i !== want.updated) begin
            $error("tempo_updated: expected %0d, actual %0d", want.updated, tempo_updated_i);
            mismatches_o++;
          end
          if (interval_accepted_i !== want.accepted) begin
            $error("interval_accepted: expected %0d, actual %0d", want.accepted,
                   interval_accepted_i);
            mismatches_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MIN_INTERVAL: lim_min = cfg_data_i;
          CFG_MAX_INTERVAL: lim_max = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) reports_q.push_back(predict_tap_report(tap_time_us_i));
      pending_o = reports_q.size();
    end
  end

endmodule

@@ tb/tap_tempo_estimator_core_tb.sv @@
// ----------------------------------------------------------------------------
// Tap tempo estimator testbench
// Drives taps through directed corner cases (limit edges, ring wrap, timestamp
// wrap, saturation, crossed limits) and then random phases under several limit
// settings, with random gaps and stalls on both sides and one long output hold.
// ----------------------------------------------------------------------------
module tap_tempo_estimator_core_tb;
  import tte_pkg::*;

  localparam int unsigned CycleLimit = 300000;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_valid = 1'b0;
  cfg_idx_e    cfg_index = CFG_MIN_INTERVAL;
  logic [23:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic [31:0] tap_time  = '0;
  logic        out_ready = 1'b0;
  logic        cfg_ready;
  logic        in_ready;
  logic        out_valid;
  logic [19:0] tempo_bpm_q8;
  logic        tempo_updated;
  logic        interval_accepted;
  int unsigned mismatches;
  int unsigned pending;

  logic        no_idle   = 1'b0;
  logic [23:0] cur_min   = 24'd150000;
  logic [23:0] cur_max   = 24'd2500000;
  logic [31:0] tap_clock = '0;
  int unsigned cycles    = 0;

  tap_tempo_estimator_core uut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .tap_time_us_i       (tap_time),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .tempo_bpm_q8_o      (tempo_bpm_q8),
    .tempo_updated_o     (tempo_updated),
    .interval_accepted_o (interval_accepted)
  );

  tempo_report_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .tap_time_us_i       (tap_time),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .tempo_bpm_q8_i      (tempo_bpm_q8),
    .tempo_updated_i     (tempo_updated),
    .interval_accepted_i (interval_accepted),
    .mismatches_o        (mismatches),
    .pending_o           (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Keep valid high across back-to-back requests; lower it only ahead of a gap.
  task automatic send_tap(input logic [31:0] t);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tap_time <= t;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic tap_after(input logic [31:0] delta);
    tap_clock = tap_clock + delta;
    send_tap(tap_clock);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [23:0] lo, input logic [23:0] hi);
    cur_min = lo;
    cur_max = hi;
    write_reg(CFG_MIN_INTERVAL, lo);
    write_reg(CFG_MAX_INTERVAL, hi);
  endtask

  // Drain every pending report, then let the sequencer fall back to idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_tap();
    int unsigned pick;
    int unsigned lo;
    int unsigned hi;
    logic [31:0] d;
    pick = $urandom_range(0, 99);
    lo   = cur_min;
    hi   = cur_max;
    if (pick < 80 && hi > lo + 1) d = $urandom_range(lo + 1, hi - 1);
    else if (pick < 88) d = pick[0] ? lo : hi;
    else if (pick < 94) d = $urandom_range(hi, 32'hFFFF_FFFF);
    else d = $urandom - tap_clock;  // arbitrary timestamp
    tap_after(d);
  endtask

  // Report side: random stalls, plus one long hold to back the core up.
  initial begin : drain
    int unsigned pause;
    int unsigned taken;
    taken = 0;
    @(posedge rst_n);
    forever begin
      pause = no_idle ? 0 : $urandom_range(0, 8);
      if (taken == 60) pause = 300;
      if (pause != 0) begin
        out_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned mn;
    int unsigned mx;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits: first tap, limit edges, restart after reject, ring wrap
    tap_clock = '0;
    send_tap(tap_clock);
    tap_after(32'd150001);
    tap_after(32'd2499999);
    tap_after(32'd150000);
    tap_after(32'd2500000);
    tap_after(32'd500000);
    repeat (9) tap_after(32'd600000);
    // timestamp wrap
    tap_clock = 32'hFFFF_FFFF;
    send_tap(tap_clock);
    tap_after(32'd400000);
    tap_clock = '0;
    send_tap(tap_clock);

    // widest limits: zero interval, tiny intervals saturate, widest edges
    settle();
    set_limits(24'h000000, 24'hFFFFFF);
    tap_after(32'd0);
    tap_after(32'd1);
    tap_after(32'd1);
    tap_after(32'h00FF_FFFE);
    tap_after(32'h00FF_FFFF);

    // crossed limits: nothing can be accepted
    settle();
    set_limits(24'hFFFFFF, 24'h000000);
    tap_after(32'd1000);
    settle();
    set_limits(24'd100, 24'd101);
    tap_after(32'd100);
    tap_after(32'd101);

    for (int p = 0; p < 8; p++) begin
      settle();
      kind = (p < 6) ? p : $urandom_range(0, 5);
      case (kind)
        0: begin mn = 150000; mx = 2500000; end
        1: begin mn = $urandom_range(0, 1000000); mx = mn + $urandom_range(2, 3000000); end
        2: begin mn = 0; mx = 24'hFFFFFF; end
        3: begin mn = $urandom_range(0, 50); mx = $urandom_range(200, 20000); end
        4: begin mn = $urandom_range(1000, 24'hFFFFFF); mx = $urandom_range(0, mn); end
        default: begin mn = $urandom_range(0, 24'hFFFFFD); mx = 24'hFFFFFF; end
      endcase
      set_limits(mn[23:0], mx[23:0]);
      no_idle = (p % 4 == 1);
      repeat (50) random_tap();
    end

    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
